// File: rtl/ncdf_pkg.sv
// Package for the normal CDF and PDF unit: formats, constants and exponential tables.
package ncdf_pkg;

  localparam int unsigned EXP_TABLE_BITS = 8;
  localparam int unsigned FRAC_SHIFT     = 16 - EXP_TABLE_BITS;
  localparam int unsigned TBL_LEN        = (1 << EXP_TABLE_BITS) + 1;
  localparam int unsigned INT_ENTRIES    = 33;
  localparam int unsigned TAYLOR_TERMS   = 24;

  localparam int unsigned DIV_BITS   = 17;
  localparam int unsigned HORNER_LEN = 5;

  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
  localparam logic [14:0] P_Q16         = 15'd21469;
  localparam logic [14:0] PDF_SCALE_Q16 = 15'd26145;

  localparam logic signed [23:0] A1_Q16 = 24'sd16701;
  localparam logic signed [23:0] A2_Q16 = -24'sd18645;
  localparam logic signed [23:0] A3_Q16 = 24'sd93154;
  localparam logic signed [23:0] A4_Q16 = -24'sd95234;
  localparam logic signed [23:0] A5_Q16 = 24'sd69560;

  typedef logic [30:0] frac_tbl_t [TBL_LEN];
  typedef logic [30:0] int_tbl_t  [INT_ENTRIES];
  typedef logic signed [23:0] coef_tbl_t [HORNER_LEN];

  localparam coef_tbl_t HORNER_ADD = '{A4_Q16, A3_Q16, A2_Q16, A1_Q16, 24'sd0};

  // Divider state carried through the reciprocal stages.
  typedef struct packed {
    logic        neg;
    logic [30:0] ex;
    logic [17:0] denom;
    logic [16:0] low;
    logic [18:0] rem;
    logic [16:0] quo;
  } div_stage_t;

  function automatic logic [30:0] exp_frac_entry(input int unsigned k);
    logic [63:0]  x;
    logic [63:0]  mag;
    logic [63:0]  prod;
    longint       sum;
    x    = 64'(k) << (30 - EXP_TABLE_BITS);
    sum  = 64'sd1 << 30;
    mag  = 64'd1 << 30;
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      prod = (mag * x + (64'd1 << 29)) >> 30;
      mag  = prod / 64'(n);
      if (n[0]) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    return (sum < 0) ? 31'd0 : sum[30:0];
  endfunction

  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t tbl;
    for (int unsigned k = 0; k < TBL_LEN; k++) begin
      tbl[k] = exp_frac_entry(k);
    end
    return tbl;
  endfunction

  function automatic int_tbl_t build_int_tbl();
    int_tbl_t    tbl;
    logic [63:0] e1;
    logic [63:0] acc;
    e1  = 64'(exp_frac_entry(TBL_LEN - 1));
    acc = 64'd1 << 30;
    tbl[0] = acc[30:0];
    for (int unsigned n = 1; n < INT_ENTRIES; n++) begin
      acc    = (acc * e1 + (64'd1 << 29)) >> 30;
      tbl[n] = acc[30:0];
    end
    return tbl;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();
  localparam int_tbl_t  INT_TBL  = build_int_tbl();

  // Signed rounding to nearest, halves away from zero.
  function automatic logic signed [63:0] srnd(input logic signed [63:0] v,
                                              input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -signed'(r) : signed'(r);
  endfunction

endpackage

// File: rtl/normal_cdf_pdf_unit.sv
// Pipelined standard normal CDF and PDF of one Q4.12 argument.
// A transaction is accepted at a rising edge where start is high and busy is low.
// Busy is always low: the pipeline takes a new argument in every cycle.
// The argument z enters as in_z_value in signed Q4.12.
// The results appear on out_cdf_value (Q0.16, 65536 means one) and
// out_pdf_value (Q0.16) for exactly one cycle, marked by out_valid.
// A result is shown once its argument has passed the whole pipeline,
// and results leave in the order of their arguments, one per cycle at most.
// The latency is set by the bit-serial reciprocal of 1 + p*u, seventeen stages,
// and the five Horner steps of two stages each.
// The exponential uses constant tables with linear interpolation.
// Reset clears every valid bit, so no result is shown until a new argument
// has passed the whole pipeline. The receiver cannot stall the block.
module normal_cdf_pdf_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_z_value,
  output logic        out_valid,
  output logic [16:0] out_cdf_value,
  output logic [14:0] out_pdf_value
);
  import ncdf_pkg::*;

  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic              neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r;
  logic [16:0]       a1_r;
  logic [30:0]       sq2_r, ua2_r;
  logic [21:0]       w3_r;
  logic [18:0]       u3_r;
  logic [32:0]       up4_r;
  logic [30:0]       f0_4_r, f1_4_r, it4_r;
  logic [FRAC_SHIFT-1:0] r4_r;
  logic              zf4_r, zf5_r, zf6_r;
  logic [17:0]       den5_r, den6_r;
  logic [30+FRAC_SHIFT:0] dr5_r;
  logic [30:0]       f0_5_r, it5_r, it6_r, ef6_r;

  logic [15:0]       raw;
  logic [5:0]        n_int;
  logic [EXP_TABLE_BITS-1:0] i_idx;
  logic [EXP_TABLE_BITS:0]   i_nxt;
  logic              zf_nxt;
  logic [5:0]        n_idx;
  logic [61:0]       ex_prod;
  logic [30:0]       ex_nxt;
  logic [17:0]       den_half;

  div_stage_t        div_r   [DIV_BITS+1];
  logic              div_v_r [DIV_BITS+1];

  assign busy = 1'b0;
  assign raw  = in_z_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    n_int  = w3_r[21:16];
    i_idx  = w3_r[15:FRAC_SHIFT];
    i_nxt  = {1'b0, i_idx} + 1'b1;
    zf_nxt = (n_int >= 6'(INT_ENTRIES));
    n_idx  = zf_nxt ? 6'd0 : n_int;
    ex_prod = 62'(it6_r) * 62'(ef6_r);
    ex_nxt  = zf6_r ? 31'd0 : 31'((ex_prod + (62'd1 << 29)) >> 30);
    den_half = den6_r >> 1;
  end

  always_ff @(posedge clk) begin
    neg1_r <= raw[15];
    a1_r   <= raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};

    neg2_r <= neg1_r;
    sq2_r  <= 31'(a1_r) * 31'(a1_r);
    ua2_r  <= 31'(a1_r) * 31'(INV_SQRT2_Q16);

    neg3_r <= neg2_r;
    w3_r   <= 22'((32'(sq2_r) + 32'd256) >> 9);
    u3_r   <= 19'((32'(ua2_r) + 32'd2048) >> 12);

    neg4_r <= neg3_r;
    up4_r  <= 33'(u3_r) * 33'(P_Q16);
    f0_4_r <= FRAC_TBL[i_idx];
    f1_4_r <= FRAC_TBL[i_nxt];
    it4_r  <= INT_TBL[n_idx];
    r4_r   <= w3_r[FRAC_SHIFT-1:0];
    zf4_r  <= zf_nxt;

    neg5_r <= neg4_r;
    den5_r <= 18'(34'd65536 + ((34'(up4_r) + 34'd32768) >> 16));
    dr5_r  <= (31+FRAC_SHIFT)'(f0_4_r - f1_4_r) * (31+FRAC_SHIFT)'(r4_r);
    f0_5_r <= f0_4_r;
    it5_r  <= it4_r;
    zf5_r  <= zf4_r;

    neg6_r <= neg5_r;
    den6_r <= den5_r;
    ef6_r  <= f0_5_r
              - 31'((dr5_r + (32+FRAC_SHIFT)'(1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
    it6_r  <= it5_r;
    zf6_r  <= zf5_r;

    div_r[0].neg   <= neg6_r;
    div_r[0].ex    <= ex_nxt;
    div_r[0].denom <= den6_r;
    div_r[0].low   <= den_half[16:0];
    div_r[0].rem   <= 19'd32768;
    div_r[0].quo   <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r[0] <= 1'b0;
    end else begin
      div_v_r[0] <= v6_r;
    end
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    localparam int unsigned BIT = DIV_BITS - 1 - g;
    logic [18:0] rem_sh;
    logic        fits;
    div_stage_t  div_nxt;

    always_comb begin
      rem_sh  = {div_r[g].rem[17:0], div_r[g].low[BIT]};
      fits    = (rem_sh >= {1'b0, div_r[g].denom});
      div_nxt = div_r[g];
      div_nxt.rem      = fits ? (rem_sh - {1'b0, div_r[g].denom}) : rem_sh;
      div_nxt.quo[BIT] = fits;
    end

    always_ff @(posedge clk) begin
      div_r[g+1] <= div_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[g+1] <= 1'b0;
      end else begin
        div_v_r[g+1] <= div_v_r[g];
      end
    end
  end

  logic              hm_v_r   [HORNER_LEN];
  logic              hm_neg_r [HORNER_LEN];
  logic [30:0]       hm_ex_r  [HORNER_LEN];
  logic [16:0]       hm_t_r   [HORNER_LEN];
  logic signed [41:0] hm_p_r  [HORNER_LEN];
  logic              ha_v_r   [HORNER_LEN+1];
  logic              ha_neg_r [HORNER_LEN+1];
  logic [30:0]       ha_ex_r  [HORNER_LEN+1];
  logic [16:0]       ha_t_r   [HORNER_LEN+1];
  logic signed [23:0] ha_h_r  [HORNER_LEN+1];

  always_comb begin
    ha_v_r[0]   = div_v_r[DIV_BITS];
    ha_neg_r[0] = div_r[DIV_BITS].neg;
    ha_ex_r[0]  = div_r[DIV_BITS].ex;
    ha_t_r[0]   = div_r[DIV_BITS].quo;
    ha_h_r[0]   = A5_Q16;
  end

  for (genvar k = 0; k < HORNER_LEN; k++) begin : g_horner
    logic signed [63:0] rnd;

    assign rnd = srnd(64'(hm_p_r[k]), 16);

    always_ff @(posedge clk) begin
      hm_neg_r[k] <= ha_neg_r[k];
      hm_ex_r[k]  <= ha_ex_r[k];
      hm_t_r[k]   <= ha_t_r[k];
      hm_p_r[k]   <= 42'(ha_h_r[k]) * 42'(signed'({1'b0, ha_t_r[k]}));

      ha_neg_r[k+1] <= hm_neg_r[k];
      ha_ex_r[k+1]  <= hm_ex_r[k];
      ha_t_r[k+1]   <= hm_t_r[k];
      ha_h_r[k+1]   <= 24'(rnd[23:0] + HORNER_ADD[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hm_v_r[k]   <= 1'b0;
        ha_v_r[k+1] <= 1'b0;
      end else begin
        hm_v_r[k]   <= ha_v_r[k];
        ha_v_r[k+1] <= hm_v_r[k];
      end
    end
  end

  logic              f1_v_r, f2_v_r;
  logic              f1_neg_r;
  logic signed [55:0] f1_prod_r;
  logic [45:0]       f1_pdf_r;
  logic signed [29:0] f2_c_r;
  logic [14:0]       f2_pdf_r;
  logic signed [63:0] prod17;
  logic signed [29:0] c_nxt;
  logic [45:0]       pdf_rnd;
  logic signed [63:0] cdf_rnd;
  logic [16:0]       cdf_nxt;

  always_comb begin
    prod17  = srnd(64'(f1_prod_r), 29);
    c_nxt   = f1_neg_r ? prod17[29:0] : (30'sd262144 - prod17[29:0]);
    pdf_rnd = (f1_pdf_r + (46'd1 << 29)) >> 30;
    cdf_rnd = srnd(64'(f2_c_r), 2);
    priority if (cdf_rnd < 64'sd0) begin
      cdf_nxt = 17'd0;
    end else if (cdf_rnd > 64'sd65536) begin
      cdf_nxt = 17'd65536;
    end else begin
      cdf_nxt = cdf_rnd[16:0];
    end
  end

  always_ff @(posedge clk) begin
    f1_neg_r  <= ha_neg_r[HORNER_LEN];
    f1_prod_r <= 56'(ha_h_r[HORNER_LEN]) * 56'(signed'({1'b0, ha_ex_r[HORNER_LEN]}));
    f1_pdf_r  <= 46'(ha_ex_r[HORNER_LEN]) * 46'(PDF_SCALE_Q16);

    f2_c_r    <= c_nxt;
    f2_pdf_r  <= (pdf_rnd > 46'(PDF_SCALE_Q16)) ? PDF_SCALE_Q16 : pdf_rnd[14:0];

    out_cdf_value <= cdf_nxt;
    out_pdf_value <= f2_pdf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r    <= 1'b0;
      f2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      f1_v_r    <= ha_v_r[HORNER_LEN];
      f2_v_r    <= f1_v_r;
      out_valid <= f2_v_r;
    end
  end

endmodule

// File: tb/sv/normal_cdf_pdf_unit_tb.sv
// Self-checking testbench for the pipelined normal CDF and PDF unit, with its own predictor.
module normal_cdf_pdf_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_BITS = 8;
  localparam int unsigned FSHIFT   = 16 - TBL_BITS;
  localparam int unsigned FLEN     = (1 << TBL_BITS) + 1;
  localparam int unsigned NLEN     = 33;

  typedef struct {
    logic [16:0] cdf;
    logic [14:0] pdf;
    logic [15:0] z;
  } normal_result_t;

  class normal_scoreboard;
    longint unsigned    frac_exp[FLEN];
    longint unsigned    int_exp[NLEN];
    normal_result_t     pending[$];
    int                 errors;

    function new();
      longint unsigned x, mag;
      longint          sum;
      errors = 0;
      for (int k = 0; k < FLEN; k++) begin
        x   = longint'(k) << (30 - TBL_BITS);
        sum = 64'sd1 << 30;
        mag = 64'd1 << 30;
        for (int n = 1; n <= 24; n++) begin
          mag = ((mag * x + (64'd1 << 29)) >> 30) / n;
          if (n % 2 == 1) sum -= longint'(mag);
          else sum += longint'(mag);
        end
        frac_exp[k] = (sum < 0) ? 0 : sum;
      end
      int_exp[0] = 64'd1 << 30;
      for (int n = 1; n < NLEN; n++)
        int_exp[n] = (int_exp[n-1] * frac_exp[FLEN-1] + (64'd1 << 29)) >> 30;
    endfunction

    function longint round_half_away(longint v, int s);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned neg_exp(longint unsigned w);
      longint unsigned n, f, i, r, ef;
      n = w >> 16;
      f = w & 16'hFFFF;
      i = f >> FSHIFT;
      r = f & ((64'd1 << FSHIFT) - 1);
      if (n >= NLEN) return 0;
      ef = frac_exp[i] - (((frac_exp[i] - frac_exp[i+1]) * r + (64'd1 << (FSHIFT-1))) >> FSHIFT);
      return (int_exp[n] * ef + (64'd1 << 29)) >> 30;
    endfunction

    function void note_argument(logic [15:0] z);
      normal_result_t  e;
      bit              neg;
      longint unsigned a, w, ex, u, den, t, pdf;
      longint          h, prod, y, c, cdf;
      neg = z[15];
      a   = neg ? (65536 - z) : z;
      w   = (a * a + 256) >> 9;
      ex  = neg_exp(w);
      u   = (a * 46341 + 2048) >> 12;
      den = 65536 + ((u * 21469 + 32768) >> 16);
      t   = ((64'd1 << 32) + den / 2) / den;
      h = 69560;
      h = round_half_away(h * longint'(t), 16) - 95234;
      h = round_half_away(h * longint'(t), 16) + 93154;
      h = round_half_away(h * longint'(t), 16) - 18645;
      h = round_half_away(h * longint'(t), 16) + 16701;
      h = round_half_away(h * longint'(t), 16);
      prod = round_half_away(h * longint'(ex), 29);
      y    = 131072 - prod;
      c    = neg ? (131072 - y) : (131072 + y);
      cdf  = round_half_away(c, 2);
      if (cdf < 0) cdf = 0;
      if (cdf > 65536) cdf = 65536;
      pdf = (26145 * ex + (64'd1 << 29)) >> 30;
      if (pdf > 26145) pdf = 26145;
      e.cdf = cdf[16:0];
      e.pdf = pdf[14:0];
      e.z   = z;
      pending.push_back(e);
    endfunction

    function void check_result(logic [16:0] cdf, logic [14:0] pdf);
      normal_result_t e;
      if (pending.size() == 0) begin
        $error("Result with no transaction outstanding: cdf %0d pdf %0d", cdf, pdf);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (cdf !== e.cdf) begin
        $error("cdf_value for z %h: expected %0d, actual %0d", e.z, e.cdf, cdf);
        errors++;
      end
      if (pdf !== e.pdf) begin
        $error("pdf_value for z %h: expected %0d, actual %0d", e.z, e.pdf, pdf);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_z_value = '0;
  logic               out_valid;
  logic [16:0]        out_cdf_value;
  logic [14:0]        out_pdf_value;

  normal_scoreboard scoreboard = new();

  normal_cdf_pdf_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_z_value(in_z_value), .out_valid(out_valid),
    .out_cdf_value(out_cdf_value), .out_pdf_value(out_pdf_value)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) scoreboard.note_argument(in_z_value);
    if (rst_n && out_valid) scoreboard.check_result(out_cdf_value, out_pdf_value);
  end

  task automatic send_argument(input logic [15:0] z);
    start      <= 1'b1;
    in_z_value <= z;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [15:0] random_argument();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
      2: return 16'($urandom_range(0, 24576)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
      default: return 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
    endcase
  endfunction

  initial begin
    logic [15:0] directed[$];
    int          burst;
    int          waited;
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                 16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000,
                 16'h5A82, 16'hA57E, 16'h0100, 16'hFF00, 16'h3FFF, 16'hC001,
                 16'h5555, 16'hAAAA, 16'h00FF, 16'h6000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_argument(directed[i]);
    for (int n = 0; n < 1150; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_argument(random_argument());
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    start <= 1'b0;
    waited = 0;
    while (scoreboard.pending.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (45) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (scoreboard.pending.size() != 0)
        $error("%0d expected results never arrived", scoreboard.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: normal_cdf_pdf_unit.f
rtl/ncdf_pkg.sv
rtl/normal_cdf_pdf_unit.sv
tb/sv/normal_cdf_pdf_unit_tb.sv
